// File: rtl/b64e_pkg.sv
// shared types, constants and the sextet-to-ascii mapping for the base64 encoder
`timescale 1ns / 1ps

package b64e_pkg;

   localparam int CHARS_PER_ENTRY = 4;
   localparam int CHAR_IDX_W      = 2;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_block;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       out_last;
      logic       block_done;
   } rsp_type;

   // one classified byte: the characters it produces, ready to serialize
   typedef struct packed {
      logic [CHARS_PER_ENTRY-1:0][7:0] chars;
      logic [CHAR_IDX_W-1:0]           last_idx;
      logic                            done;
   } entry_type;

   // standard alphabet: A-Z, a-z, 0-9, '+', '/'
   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] code;
      code = {2'b00, v};
      if (v < 6'd26) begin
         sextet_char = code + 8'd65;
      end else if (v < 6'd52) begin
         sextet_char = code + 8'd71;
      end else if (v < 6'd62) begin
         sextet_char = code - 8'd4;
      end else if (v == 6'd62) begin
         sextet_char = 8'h2B;
      end else begin
         sextet_char = 8'h2F;
      end
   endfunction

endpackage

// File: rtl/base64_stream_encoder.sv
// top level of the padded base64 stream encoder
`timescale 1ns / 1ps

// Padded base64 encoder for a byte stream. Each req transfer carries one raw byte and a
// flag marking the final byte of a block; each rsp transfer carries one ASCII character
// (A-Z a-z 0-9 + / or '=') with out_last on the final character of a byte and block_done
// on the final character of the block. Bytes are classified by the front end, which keeps
// the group phase and the leftover bits, and land in a QUEUE_DEPTH-entry queue; the back
// end drains that queue at one character per cycle while rsp_ready does not stall it. The
// character serializer sets the rate: a byte takes as many transfers as characters it
// makes, 1, 1 and 2 across a group of three, and up to 4 for a final byte that needs
// "==" padding. The first character of a byte passes through the queue and then the
// output register before it is on the rsp port. The front keeps accepting bytes while
// the queue has room, also when the output stalls. QUEUE_DEPTH must be at least 2.

module base64_stream_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   // byte input
   input  logic              req_valid,
   output logic              req_ready,
   input  b64e_pkg::req_type req_data,
   // character output
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output b64e_pkg::rsp_type rsp_data
);
   import b64e_pkg::*;

   // front to queue
   logic      push_valid;
   logic      push_ready;
   entry_type push_entry;

   // queue to back
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_entry;

   // phase/carry tracking and character selection
   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // decoupling queue, lets input run on while output stalls
   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // one character per transfer into the output register
   b64e_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // end of block always closes the byte's character run
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.block_done |-> rsp_data.out_last)
      else $error("block_done without out_last");

   // padding only ever closes a block
   a_pad_ends_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_char == PAD_CHAR && rsp_data.out_last
         |-> rsp_data.block_done)
      else $error("padding character outside block end");

   // input backpressure only when the queue holds work for the back end
   a_stall_has_work: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> pop_valid)
      else $error("input stalled with empty queue");

   // a popped entry must have gone into the output register
   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      pop_valid && pop_ready |=> rsp_valid && rsp_data.out_last)
      else $error("entry popped without final character shown");

endmodule

// File: rtl/b64e_front.sv
// front end: accepts bytes, tracks group phase and carry, builds character entries
`timescale 1ns / 1ps

module b64e_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  b64e_pkg::req_type   req_data,
   output logic                push_valid,
   input  logic                push_ready,
   output b64e_pkg::entry_type push_entry
);
   import b64e_pkg::*;

   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [3:0] carry_ff, carry_in;
   logic [7:0] b;
   logic       last;
   logic       take;

   assign b          = req_data.data_byte;
   assign last       = req_data.end_of_block;
   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign take       = req_valid && push_ready;

   always_comb begin
      push_entry.chars    = {CHARS_PER_ENTRY{PAD_CHAR}};
      push_entry.last_idx = '0;
      push_entry.done     = last;
      phase_in            = PHASE_SECOND;
      carry_in            = b[3:0];
      case (phase_ff)
         PHASE_SECOND: begin
            push_entry.chars[0] = sextet_char({carry_ff[1:0], b[7:4]});
            if (last) begin
               push_entry.chars[1] = sextet_char({b[3:0], 2'b00});
               push_entry.last_idx = 2'd2;
            end
            phase_in = PHASE_THIRD;
         end
         PHASE_THIRD: begin
            push_entry.chars[0] = sextet_char({carry_ff, b[7:6]});
            push_entry.chars[1] = sextet_char(b[5:0]);
            push_entry.last_idx = 2'd1;
            phase_in            = PHASE_FIRST;
         end
         default: begin
            // first byte of a group, also the unused fourth code
            push_entry.chars[0] = sextet_char(b[7:2]);
            if (last) begin
               push_entry.chars[1] = sextet_char({b[1:0], 4'b0000});
               push_entry.last_idx = 2'd3;
            end
            phase_in = PHASE_SECOND;
         end
      endcase
      if (last) begin
         phase_in = PHASE_FIRST;
         carry_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_FIRST;
         carry_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

// File: rtl/b64e_queue.sv
// small fifo of classified entries between front and back
`timescale 1ns / 1ps

module b64e_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  b64e_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output b64e_pkg::entry_type pop_entry
);
   import b64e_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/b64e_back.sv
// back end: serializes entry characters into the registered result channel
`timescale 1ns / 1ps

module b64e_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  b64e_pkg::entry_type pop_entry,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output b64e_pkg::rsp_type   rsp_data
);
   import b64e_pkg::*;

   logic [CHAR_IDX_W-1:0] idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   rsp_type               data_ff, data_in;
   logic                  load;
   logic                  final_char;

   assign load       = pop_valid && (!valid_ff || rsp_ready);
   assign final_char = (idx_ff == pop_entry.last_idx);
   assign pop_ready  = load && final_char;
   assign rsp_valid  = valid_ff;
   assign rsp_data   = data_ff;

   always_comb begin
      idx_in              = idx_ff;
      valid_in            = valid_ff && !rsp_ready;
      data_in             = data_ff;
      if (load) begin
         valid_in            = 1'b1;
         data_in.out_char    = pop_entry.chars[idx_ff];
         data_in.out_last    = final_char;
         data_in.block_done  = final_char && pop_entry.done;
         idx_in              = final_char ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

endmodule
